// ===== rtl/mhtm_pkg.sv =====
// Package for the min-heap timer manager: command, result and op codes,
// plus the control/status structs between controller and datapath.
// No dependencies.
package mhtm_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int ID_SPACE_DEF = 256;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // request commands
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_ADJUST = 3'd2;
   localparam logic [2:0] CMD_QUERY  = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_EXPIRED = 2'd0;
   localparam logic [1:0] KIND_DELAY   = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_FULL    = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN = 2'd2;

   // datapath operations
   localparam logic [4:0] OP_NONE        = 5'd0;
   localparam logic [4:0] OP_LOAD        = 5'd1;
   localparam logic [4:0] OP_TICK        = 5'd2;
   localparam logic [4:0] OP_ERR_FULL    = 5'd3;
   localparam logic [4:0] OP_ERR_UNKNOWN = 5'd4;
   localparam logic [4:0] OP_CLEAR       = 5'd5;
   localparam logic [4:0] OP_ADD_NEW     = 5'd6;
   localparam logic [4:0] OP_RD_POS      = 5'd7;
   localparam logic [4:0] OP_RT_START    = 5'd8;
   localparam logic [4:0] OP_RT_SETV     = 5'd9;
   localparam logic [4:0] OP_RD_TOP      = 5'd10;
   localparam logic [4:0] OP_EMIT_EXP    = 5'd11;
   localparam logic [4:0] OP_RD_LAST     = 5'd12;
   localparam logic [4:0] OP_LATCH_V     = 5'd13;
   localparam logic [4:0] OP_DN_L        = 5'd14;
   localparam logic [4:0] OP_DN_R        = 5'd15;
   localparam logic [4:0] OP_DN_SEL      = 5'd16;
   localparam logic [4:0] OP_DN_MOVE     = 5'd17;
   localparam logic [4:0] OP_WR_HOLE     = 5'd18;
   localparam logic [4:0] OP_RD_BASE     = 5'd19;
   localparam logic [4:0] OP_RD_PAR      = 5'd20;
   localparam logic [4:0] OP_UP_MOVE     = 5'd21;
   localparam logic [4:0] OP_EMIT_DELAY  = 5'd22;
   localparam logic [4:0] OP_EMIT_EMPTY  = 5'd23;
   localparam logic [4:0] OP_EMIT_DONE   = 5'd24;

   typedef struct packed {
      logic [4:0] op;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       id_oor;
      logic       id_present;
      logic       full;
      logic       empty;
      logic       pos_ok;
      logic       has_left;
      logic       is_root;
      logic       due;
      logic       v_before_c;
      logic       v_before_q;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== rtl/mhtm_datapath.sv =====
// Datapath of the timer manager: heap and position memories, presence bits,
// time counter, sift registers and the result register.
// Depends on mhtm_pkg.
module mhtm_datapath #(
   parameter int CAPACITY = mhtm_pkg::CAPACITY_DEF,
   parameter int ID_SPACE = mhtm_pkg::ID_SPACE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mhtm_pkg::ctl_cmd_type           ctl,
   output mhtm_pkg::dp_status_type         sts,
   input  logic [mhtm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mhtm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IDW = $clog2(ID_SPACE);
   localparam int LW  = IW + 2;
   localparam int EW  = 40;

   logic [EW-1:0]  heap_mem [CAPACITY];
   logic [IW-1:0]  pos_mem  [ID_SPACE];

   logic [2:0]     cmd_ff;
   logic [7:0]     id_ff;
   logic [30:0]    tmo_ff;
   logic [1:0]     err_ff;
   logic [31:0]    now_ff;
   logic [CW-1:0]  count_ff;
   logic [ID_SPACE-1:0] present_ff;
   logic [7:0]     v_id_ff;
   logic [31:0]    v_exp_ff;
   logic [7:0]     c_id_ff;
   logic [31:0]    c_exp_ff;
   logic [IW-1:0]  hole_ff;
   logic [IW-1:0]  base_ff;
   logic [IW-1:0]  child_ff;
   logic [EW-1:0]  q_ff;
   logic [IW-1:0]  pos_q_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [1:0]     rsp_kind_ff;
   logic [7:0]     rsp_id_ff;
   logic [30:0]    rsp_delay_ff;
   logic           rsp_empty_ff;
   logic [1:0]     rsp_err_ff;
   logic           rsp_last_ff;

   logic [7:0]     q_id;
   logic [31:0]    q_exp;
   logic [IDW-1:0] id_idx;
   logic [LW-1:0]  left;
   logic [LW-1:0]  right;
   logic [LW-1:0]  count_ext;
   logic [IW-1:0]  parent;
   logic [31:0]    new_exp;
   logic [31:0]    dq;
   logic [31:0]    d_vc;
   logic [31:0]    d_vq;
   logic [31:0]    d_qc;
   logic           id_oor;
   logic           out_free;
   logic           rd_en;
   logic [IW-1:0]  rd_addr;
   logic           wr_en;
   logic [IW-1:0]  wr_addr;
   logic [EW-1:0]  wr_data;

   assign q_id      = q_ff[EW-1:32];
   assign q_exp     = q_ff[31:0];
   assign id_idx    = IDW'(id_ff);
   assign left      = LW'({hole_ff, 1'b1});
   assign right     = LW'(child_ff) + LW'(1);
   assign count_ext = LW'(count_ff);
   assign parent    = (hole_ff - IW'(1)) >> 1;
   assign new_exp   = now_ff + {1'b0, tmo_ff};
   assign dq        = q_exp - now_ff;
   assign d_vc      = v_exp_ff - c_exp_ff;
   assign d_vq      = v_exp_ff - q_exp;
   assign d_qc      = q_exp - c_exp_ff;
   assign id_oor    = 32'(id_ff) >= 32'(ID_SPACE);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sts            = '0;
      sts.cmd        = cmd_ff;
      sts.id_oor     = id_oor;
      sts.id_present = !id_oor && present_ff[id_idx];
      sts.full       = count_ff == CW'(CAPACITY);
      sts.empty      = count_ff == '0;
      sts.pos_ok     = CW'(pos_q_ff) < count_ff;
      sts.has_left   = left < count_ext;
      sts.is_root    = hole_ff == '0;
      sts.due        = (dq == '0) || dq[31];
      sts.v_before_c = d_vc[31];
      sts.v_before_q = d_vq[31];
      sts.out_free   = out_free;
   end

   // heap memory port selection
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = hole_ff;
      wr_data = {v_id_ff, v_exp_ff};
      unique case (ctl.op)
         mhtm_pkg::OP_RD_TOP:   rd_addr = '0;
         mhtm_pkg::OP_RD_LAST:  rd_addr = IW'(count_ff);
         mhtm_pkg::OP_RT_START: rd_addr = pos_q_ff;
         mhtm_pkg::OP_DN_L:     rd_addr = IW'(left);
         mhtm_pkg::OP_DN_R:     rd_addr = IW'(right);
         mhtm_pkg::OP_RD_BASE:  rd_addr = base_ff;
         mhtm_pkg::OP_RD_PAR:   rd_addr = parent;
         mhtm_pkg::OP_WR_HOLE: begin
            rd_en = 1'b0;
            wr_en = 1'b1;
         end
         mhtm_pkg::OP_DN_MOVE: begin
            rd_en   = 1'b0;
            wr_en   = 1'b1;
            wr_data = {c_id_ff, c_exp_ff};
         end
         mhtm_pkg::OP_UP_MOVE: begin
            rd_en   = 1'b0;
            wr_en   = 1'b1;
            wr_data = q_ff;
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
         pos_mem[IDW'(wr_data[EW-1:32])] <= wr_addr;
      end
      if (rd_en) begin
         q_ff <= heap_mem[rd_addr];
      end
      if (ctl.op == mhtm_pkg::OP_RD_POS) begin
         pos_q_ff <= pos_mem[id_idx];
      end
   end

   // result register fills on an emit op and drains on a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (ctl.op) inside
         mhtm_pkg::OP_EMIT_EXP, mhtm_pkg::OP_EMIT_DELAY, mhtm_pkg::OP_EMIT_EMPTY,
         mhtm_pkg::OP_EMIT_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (ctl.op)
            mhtm_pkg::OP_TICK:  now_ff <= now_ff + 32'd1;
            mhtm_pkg::OP_CLEAR: begin
               count_ff   <= '0;
               present_ff <= '0;
            end
            mhtm_pkg::OP_ADD_NEW: begin
               count_ff           <= count_ff + CW'(1);
               present_ff[id_idx] <= 1'b1;
            end
            mhtm_pkg::OP_EMIT_EXP: begin
               count_ff               <= count_ff - CW'(1);
               present_ff[IDW'(q_id)] <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (ctl.op)
         mhtm_pkg::OP_LOAD: begin
            cmd_ff <= req_tuser;
            id_ff  <= req_tdata[7:0];
            tmo_ff <= req_tdata[38:8];
            err_ff <= mhtm_pkg::ERR_NONE;
         end
         mhtm_pkg::OP_ERR_FULL:    err_ff <= mhtm_pkg::ERR_FULL;
         mhtm_pkg::OP_ERR_UNKNOWN: err_ff <= mhtm_pkg::ERR_UNKNOWN;
         mhtm_pkg::OP_ADD_NEW: begin
            hole_ff  <= IW'(count_ff);
            base_ff  <= IW'(count_ff);
            v_id_ff  <= id_ff;
            v_exp_ff <= new_exp;
         end
         mhtm_pkg::OP_RT_START: begin
            hole_ff <= pos_q_ff;
            base_ff <= pos_q_ff;
         end
         mhtm_pkg::OP_RT_SETV: begin
            v_id_ff  <= q_id;
            v_exp_ff <= new_exp;
         end
         mhtm_pkg::OP_RD_LAST: begin
            hole_ff <= '0;
            base_ff <= '0;
         end
         mhtm_pkg::OP_LATCH_V: begin
            v_id_ff  <= q_id;
            v_exp_ff <= q_exp;
         end
         mhtm_pkg::OP_DN_L: child_ff <= IW'(left);
         mhtm_pkg::OP_DN_R: begin
            c_id_ff  <= q_id;
            c_exp_ff <= q_exp;
         end
         mhtm_pkg::OP_DN_SEL: begin
            // right child wins only when strictly earlier
            if (right < count_ext && d_qc[31]) begin
               c_id_ff  <= q_id;
               c_exp_ff <= q_exp;
               child_ff <= IW'(right);
            end
         end
         mhtm_pkg::OP_DN_MOVE: hole_ff <= child_ff;
         mhtm_pkg::OP_RD_BASE: hole_ff <= base_ff;
         mhtm_pkg::OP_UP_MOVE: hole_ff <= parent;
         default: ;
      endcase
      if (out_free) begin
         case (ctl.op)
            mhtm_pkg::OP_EMIT_EXP: begin
               rsp_kind_ff  <= mhtm_pkg::KIND_EXPIRED;
               rsp_id_ff    <= q_id;
               rsp_delay_ff <= '0;
               rsp_empty_ff <= 1'b0;
               rsp_err_ff   <= mhtm_pkg::ERR_NONE;
               rsp_last_ff  <= 1'b0;
            end
            mhtm_pkg::OP_EMIT_DELAY: begin
               rsp_kind_ff  <= mhtm_pkg::KIND_DELAY;
               rsp_id_ff    <= '0;
               rsp_delay_ff <= dq[31] ? '0 : dq[30:0];
               rsp_empty_ff <= 1'b0;
               rsp_err_ff   <= mhtm_pkg::ERR_NONE;
               rsp_last_ff  <= 1'b1;
            end
            mhtm_pkg::OP_EMIT_EMPTY: begin
               rsp_kind_ff  <= mhtm_pkg::KIND_DELAY;
               rsp_id_ff    <= '0;
               rsp_delay_ff <= '0;
               rsp_empty_ff <= 1'b1;
               rsp_err_ff   <= mhtm_pkg::ERR_NONE;
               rsp_last_ff  <= 1'b1;
            end
            mhtm_pkg::OP_EMIT_DONE: begin
               rsp_kind_ff  <= mhtm_pkg::KIND_DONE;
               rsp_id_ff    <= '0;
               rsp_delay_ff <= '0;
               rsp_empty_ff <= 1'b0;
               rsp_err_ff   <= err_ff;
               rsp_last_ff  <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_err_ff, rsp_empty_ff, rsp_delay_ff, rsp_id_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("heap count above capacity");

   a_expire_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.op == mhtm_pkg::OP_EMIT_EXP |-> count_ff != '0)
      else $error("expiry from empty heap");

   a_expire_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.op == mhtm_pkg::OP_EMIT_EXP |=> count_ff == $past(count_ff) - CW'(1))
      else $error("expiry did not shrink heap");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.op == mhtm_pkg::OP_CLEAR |=> count_ff == '0 && present_ff == '0)
      else $error("clear left timers behind");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == mhtm_pkg::OP_EMIT_EXP || ctl.op == mhtm_pkg::OP_EMIT_DONE) |-> out_free)
      else $error("result overwritten");

endmodule

// ===== rtl/mhtm_ctrl.sv =====
// Controller of the timer manager: sequences expiry, insert, retime and
// sift steps as datapath ops. Depends on mhtm_pkg.
module mhtm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  mhtm_pkg::dp_status_type sts,
   output mhtm_pkg::ctl_cmd_type   ctl
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DISP    = 5'd1;
   localparam logic [4:0] S_RT_POS  = 5'd2;
   localparam logic [4:0] S_RT_V    = 5'd3;
   localparam logic [4:0] S_EXP_RD  = 5'd4;
   localparam logic [4:0] S_EXP_CHK = 5'd5;
   localparam logic [4:0] S_RM_RD   = 5'd6;
   localparam logic [4:0] S_RM_V    = 5'd7;
   localparam logic [4:0] S_DN_L    = 5'd8;
   localparam logic [4:0] S_DN_R    = 5'd9;
   localparam logic [4:0] S_DN_SEL  = 5'd10;
   localparam logic [4:0] S_DN_CMP  = 5'd11;
   localparam logic [4:0] S_UP_B    = 5'd12;
   localparam logic [4:0] S_UP_V    = 5'd13;
   localparam logic [4:0] S_UP_RD   = 5'd14;
   localparam logic [4:0] S_UP_CMP  = 5'd15;
   localparam logic [4:0] S_DONE    = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic       remove_ff;
   logic       remove_in;
   logic [4:0] down_exit;

   assign req_tready = state_ff == S_IDLE;
   // after a sift down: removal goes back to expiry, retime continues upward
   assign down_exit  = remove_ff ? S_EXP_RD : S_UP_B;

   always_comb begin
      state_in  = state_ff;
      remove_in = remove_ff;
      ctl.op    = mhtm_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.op   = mhtm_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.cmd)
               mhtm_pkg::CMD_TICK: begin
                  ctl.op   = mhtm_pkg::OP_TICK;
                  state_in = S_EXP_RD;
               end
               mhtm_pkg::CMD_ADD: begin
                  if (sts.id_oor) begin
                     ctl.op   = mhtm_pkg::OP_ERR_FULL;
                     state_in = S_DONE;
                  end else if (sts.id_present) begin
                     ctl.op   = mhtm_pkg::OP_RD_POS;
                     state_in = S_RT_POS;
                  end else if (sts.full) begin
                     ctl.op   = mhtm_pkg::OP_ERR_FULL;
                     state_in = S_DONE;
                  end else begin
                     ctl.op   = mhtm_pkg::OP_ADD_NEW;
                     state_in = S_UP_RD;
                  end
               end
               mhtm_pkg::CMD_ADJUST: begin
                  if (!sts.id_present) begin
                     ctl.op   = mhtm_pkg::OP_ERR_UNKNOWN;
                     state_in = S_DONE;
                  end else begin
                     ctl.op   = mhtm_pkg::OP_RD_POS;
                     state_in = S_RT_POS;
                  end
               end
               mhtm_pkg::CMD_QUERY: state_in = S_EXP_RD;
               mhtm_pkg::CMD_CLEAR: begin
                  ctl.op   = mhtm_pkg::OP_CLEAR;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RT_POS: begin
            if (sts.pos_ok) begin
               ctl.op   = mhtm_pkg::OP_RT_START;
               state_in = S_RT_V;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RT_V: begin
            ctl.op    = mhtm_pkg::OP_RT_SETV;
            remove_in = 1'b0;
            state_in  = S_DN_L;
         end
         S_EXP_RD: begin
            if (!sts.empty) begin
               ctl.op   = mhtm_pkg::OP_RD_TOP;
               state_in = S_EXP_CHK;
            end else if (sts.cmd != mhtm_pkg::CMD_QUERY) begin
               state_in = S_DONE;
            end else if (sts.out_free) begin
               ctl.op   = mhtm_pkg::OP_EMIT_EMPTY;
               state_in = S_IDLE;
            end
         end
         S_EXP_CHK: begin
            if (sts.due) begin
               if (sts.out_free) begin
                  ctl.op   = mhtm_pkg::OP_EMIT_EXP;
                  state_in = S_RM_RD;
               end
            end else if (sts.cmd != mhtm_pkg::CMD_QUERY) begin
               state_in = S_DONE;
            end else if (sts.out_free) begin
               ctl.op   = mhtm_pkg::OP_EMIT_DELAY;
               state_in = S_IDLE;
            end
         end
         S_RM_RD: begin
            if (sts.empty) begin
               state_in = S_EXP_RD;
            end else begin
               ctl.op   = mhtm_pkg::OP_RD_LAST;
               state_in = S_RM_V;
            end
         end
         S_RM_V: begin
            ctl.op    = mhtm_pkg::OP_LATCH_V;
            remove_in = 1'b1;
            state_in  = S_DN_L;
         end
         S_DN_L: begin
            if (sts.has_left) begin
               ctl.op   = mhtm_pkg::OP_DN_L;
               state_in = S_DN_R;
            end else begin
               ctl.op   = mhtm_pkg::OP_WR_HOLE;
               state_in = down_exit;
            end
         end
         S_DN_R: begin
            ctl.op   = mhtm_pkg::OP_DN_R;
            state_in = S_DN_SEL;
         end
         S_DN_SEL: begin
            ctl.op   = mhtm_pkg::OP_DN_SEL;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (sts.v_before_c) begin
               ctl.op   = mhtm_pkg::OP_WR_HOLE;
               state_in = down_exit;
            end else begin
               ctl.op   = mhtm_pkg::OP_DN_MOVE;
               state_in = S_DN_L;
            end
         end
         S_UP_B: begin
            ctl.op   = mhtm_pkg::OP_RD_BASE;
            state_in = S_UP_V;
         end
         S_UP_V: begin
            ctl.op   = mhtm_pkg::OP_LATCH_V;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (sts.is_root) begin
               ctl.op   = mhtm_pkg::OP_WR_HOLE;
               state_in = S_DONE;
            end else begin
               ctl.op   = mhtm_pkg::OP_RD_PAR;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (sts.v_before_q) begin
               ctl.op   = mhtm_pkg::OP_UP_MOVE;
               state_in = S_UP_RD;
            end else begin
               ctl.op   = mhtm_pkg::OP_WR_HOLE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               ctl.op   = mhtm_pkg::OP_EMIT_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         remove_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         remove_ff <= remove_in;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.op == mhtm_pkg::OP_LOAD |-> state_ff == S_IDLE)
      else $error("request loaded while busy");

   a_load_dispatch: assert property (@(posedge clock) disable iff (reset)
      ctl.op == mhtm_pkg::OP_LOAD |=> state_ff == S_DISP)
      else $error("load not followed by dispatch");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.op == mhtm_pkg::OP_EMIT_DONE |=> state_ff == S_IDLE)
      else $error("closing result did not end command");

endmodule

// ===== rtl/min_heap_timer_manager.sv =====
// Min-heap timer manager, one command at a time; the next command is taken once
// the closing result is registered. The controller steps from accept to the
// closing result: an add of a new id climbs the heap level by level, a retime
// sifts down and then up, and each expired timer is removed with a sift down;
// a full result register stalls the controller. The heap memory is single-port,
// one read or write per cycle. Synchronous reset empties the heap and the id
// table and zeroes the time counter; no clearing pass.
module min_heap_timer_manager #(
   parameter int CAPACITY = mhtm_pkg::CAPACITY_DEF,
   parameter int ID_SPACE = mhtm_pkg::ID_SPACE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mhtm_pkg::REQ_DATA_W-1:0] req_tdata,  // timer_id[7:0], timeout_ms[38:8]
   input  logic [2:0]                      req_tuser,  // command[2:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mhtm_pkg::RSP_DATA_W-1:0] rsp_tdata,  // expired_id[7:0], delay_ms[38:8],
                                                       // no_timers[39], error_code[41:40]
   output logic [1:0]                      rsp_tuser,  // kind[1:0]
   output logic                            rsp_tlast
);

   mhtm_pkg::ctl_cmd_type   ctl;
   mhtm_pkg::dp_status_type sts;

   mhtm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   mhtm_datapath #(
      .CAPACITY (CAPACITY),
      .ID_SPACE (ID_SPACE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
